/* sv/lowercase_murmur2_string_hash_core_assert.svh */
// Assertion macros for the lower-case MurmurHash2 string hash core.
// Used by the top level; needs nothing else.
`ifndef LOWERCASE_MURMUR2_STRING_HASH_CORE_ASSERT_SVH
`define LOWERCASE_MURMUR2_STRING_HASH_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LMH_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hash core check failed");

// Next-cycle implication, checked outside reset.
`define LMH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hash core check failed");

`endif

/* sv/lmh_pkg.sv */
// Shared constants and controller/datapath interface types for the hash core.
// No dependencies.
`default_nettype none

package lmh_pkg;

  localparam int unsigned HASH_W = 32;
  localparam int unsigned LEN_W  = 16;
  localparam int unsigned BUF_W  = 24;

  localparam logic [HASH_W-1:0] MIX_MULT   = 32'h5bd1_e995;
  localparam logic [HASH_W-1:0] SEED_RESET = 32'h444f_5441;

  // Commands from the controller to the datapath; at most one is set at a time.
  typedef struct packed {
    logic accept;
    logic mix_w1;
    logic mix_w2;
    logic mix_h;
    logic tail;
    logic fin;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic take_mix;  // request in flight completes a word
    logic in_last;   // request in flight ends the string
    logic last_q;    // latched end-of-string flag of the current request
    logic out_free;  // output register can take a new hash
  } status_t;

endpackage

`default_nettype wire

/* sv/lmh_datapath.sv */
// Datapath of the hash core: byte folding and packing, the shared constant
// multiplier, hash state, seed register and output register. Uses lmh_pkg.
`default_nettype none

module lmh_datapath import lmh_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              hash_seed_we,
  input  wire logic [HASH_W-1:0] hash_seed,
  input  wire logic [7:0]        data_byte,
  input  wire logic              is_first,
  input  wire logic [LEN_W-1:0]  total_length,
  input  wire logic              is_last,
  input  wire logic              is_empty,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output logic [HASH_W-1:0]      hash_value,
  input  wire cmd_t              cmd,
  output status_t                status
);

  logic [HASH_W-1:0] seed;
  logic [HASH_W-1:0] h;
  logic [HASH_W-1:0] w;
  logic [BUF_W-1:0]  wbuf;
  logic [1:0]        cnt;
  logic              last_q;

  logic [HASH_W-1:0] h_start;
  logic [BUF_W-1:0]  buf_start;
  logic [1:0]        cnt_start;
  logic [7:0]        folded;
  logic [BUF_W-1:0]  buf_packed;
  logic [HASH_W-1:0] mul_in;
  logic [HASH_W-1:0] prod;
  logic [HASH_W-1:0] h_final;

  // A first request restarts the hash before its byte is taken in.
  assign h_start   = is_first ? (seed ^ {{(HASH_W-LEN_W){1'b0}}, total_length}) : h;
  assign buf_start = is_first ? '0 : wbuf;
  assign cnt_start = is_first ? 2'd0 : cnt;

  assign folded = (data_byte >= 8'h41 && data_byte <= 8'h5a) ? data_byte + 8'h20 : data_byte;

  always_comb begin
    buf_packed = buf_start;
    case (cnt_start)
      2'd0:    buf_packed[7:0]   = folded;
      2'd1:    buf_packed[15:8]  = folded;
      2'd2:    buf_packed[23:16] = folded;
      default: buf_packed        = buf_start;
    endcase
  end

  always_comb begin
    mul_in = h;
    if (cmd.mix_w1) begin
      mul_in = w;
    end else if (cmd.mix_w2) begin
      mul_in = w ^ (w >> 24);
    end else if (cmd.tail) begin
      mul_in = h ^ {{(HASH_W-BUF_W){1'b0}}, wbuf};
    end else if (cmd.fin) begin
      mul_in = h ^ (h >> 13);
    end
  end

  assign prod    = mul_in * MIX_MULT;
  assign h_final = h ^ (h >> 15);

  assign status.take_mix = !is_empty && (cnt_start == 2'd3);
  assign status.in_last  = is_last;
  assign status.last_q   = last_q;
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed      <= SEED_RESET;
      h         <= '0;
      wbuf      <= '0;
      cnt       <= 2'd0;
      last_q    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (hash_seed_we) begin
        seed <= hash_seed;
      end
      if (cmd.accept) begin
        h      <= h_start;
        last_q <= is_last;
        if (is_empty) begin
          wbuf <= buf_start;
          cnt  <= cnt_start;
        end else if (cnt_start == 2'd3) begin
          w    <= {folded, buf_start};
          wbuf <= '0;
          cnt  <= 2'd0;
        end else begin
          wbuf <= buf_packed;
          cnt  <= cnt_start + 2'd1;
        end
      end
      if (cmd.mix_w1 || cmd.mix_w2) begin
        w <= prod;
      end
      if (cmd.mix_h) begin
        h <= prod ^ w;
      end
      if (cmd.tail) begin
        if (cnt != 2'd0) begin
          h <= prod;
        end
        wbuf <= '0;
        cnt  <= 2'd0;
      end
      if (cmd.fin) begin
        h <= prod;
      end
      if (cmd.emit) begin
        h          <= h_final;
        hash_value <= h_final;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/lmh_ctrl.sv */
// Controller of the hash core: sequences word mixing, tail and finalizer
// steps on the shared multiplier. Uses lmh_pkg.
`default_nettype none

module lmh_ctrl import lmh_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MW1  = 3'd1;
  localparam logic [2:0] S_MW2  = 3'd2;
  localparam logic [2:0] S_MH   = 3'd3;
  localparam logic [2:0] S_TAIL = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (status.take_mix) begin
            state_next = S_MW1;
          end else if (status.in_last) begin
            state_next = S_TAIL;
          end
        end
      end
      S_MW1: begin
        cmd.mix_w1 = 1'b1;
        state_next = S_MW2;
      end
      S_MW2: begin
        cmd.mix_w2 = 1'b1;
        state_next = S_MH;
      end
      S_MH: begin
        cmd.mix_h  = 1'b1;
        state_next = status.last_q ? S_TAIL : S_IDLE;
      end
      S_TAIL: begin
        cmd.tail   = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.fin    = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        // Hold the finished hash until the output register is free.
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

/* sv/lowercase_murmur2_string_hash_core.sv */
// A string enters one byte per request; bytes are folded to lower case, packed
// little-endian and mixed by MurmurHash2 from a seed XORed with the length, and
// the last request yields the 32-bit hash. A request whose byte completes a word
// steps through mixing states MW1, MW2 and MH; a last request also steps through
// tail, finalizer and emit states. All steps share one 32x32 constant multiplier. The
// finished hash sits in an output register, so the next string can start while it
// waits. Uses lmh_pkg, lmh_ctrl, lmh_datapath and the assert header.
`default_nettype none

`include "lowercase_murmur2_string_hash_core_assert.svh"

module lowercase_murmur2_string_hash_core import lmh_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              hash_seed_we,
  input  wire logic [HASH_W-1:0] hash_seed,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        data_byte,
  input  wire logic              is_first,
  input  wire logic [LEN_W-1:0]  total_length,
  input  wire logic              is_last,
  input  wire logic              is_empty,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [HASH_W-1:0]      hash_value
);

  cmd_t    cmd;
  status_t status;

  lmh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  lmh_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .hash_seed_we (hash_seed_we),
    .hash_seed    (hash_seed),
    .data_byte    (data_byte),
    .is_first     (is_first),
    .total_length (total_length),
    .is_last      (is_last),
    .is_empty     (is_empty),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .hash_value   (hash_value),
    .cmd          (cmd),
    .status       (status)
  );

  `LMH_ASSERT_NOW(a_one_cmd, 1'b1, $onehot0(cmd))
  `LMH_ASSERT_NOW(a_emit_free, cmd.emit, status.out_free)
  `LMH_ASSERT_NEXT(a_word_mix, cmd.accept && status.take_mix, cmd.mix_w1 && !in_ready)
  `LMH_ASSERT_NEXT(a_last_tail, cmd.accept && !status.take_mix && status.in_last, cmd.tail)

endmodule

`default_nettype wire
